// ===== src/ema_filter_with_extrema_variance_defines.svh =====
// Assertion macros shared by the EMA filter RTL.
`ifndef EMA_FILTER_WITH_EXTREMA_VARIANCE_DEFINES_SVH
`define EMA_FILTER_WITH_EXTREMA_VARIANCE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define EMAEV_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define EMAEV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== src/emaev_pkg.sv =====
// Package with widths, constants and word types of the EMA filter.
package emaev_pkg;

  localparam int DATA_W  = 32;
  localparam int COEF_W  = 16;
  localparam int SQ_W    = DATA_W + COEF_W;
  localparam int DIGIT_W = 8;
  localparam int MUL_W   = SQ_W + 2;
  localparam int ACC_W   = MUL_W + DIGIT_W + 1;
  localparam int MULT_W  = DATA_W;
  localparam int CNT_W   = 2;

  localparam logic [CNT_W-1:0] CNT_COEF = CNT_W'(COEF_W / DIGIT_W - 1);
  localparam logic [CNT_W-1:0] CNT_SQR  = CNT_W'(MULT_W / DIGIT_W - 1);

  localparam logic [COEF_W-1:0] COEF_RESET = COEF_W'(58982);

  localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic                     mode;
    logic signed [DATA_W-1:0] sample;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] average;
    logic signed [DATA_W-1:0] rate;
    logic signed [DATA_W-1:0] peak_high;
    logic signed [DATA_W-1:0] peak_low;
    logic        [SQ_W-1:0]   mean_square_dev;
  } out_word_t;

endpackage

// ===== src/ema_filter_with_extrema_variance.sv =====
// EMA filter with rate, decaying extrema and mean squared deviation.
// Usage:
//   Input words (mode, sample) enter on in_valid/in_stall; result words
//   (average, rate, peak_high, peak_low, mean_square_dev) leave on
//   out_valid/out_stall. A word moves when valid is high and stall is low.
//   Coefficient (unsigned Q0.16, reset 58982, about 0.9): the user writes
//   it via cfg_wr_en/cfg_wr_data only while idle; the block won't enforce.
// Timing:
//   A filtering word runs five products on one shared digit-serial
//   multiplier that takes 8 multiplier bits per cycle: four products by
//   the coefficient and the square of the deviation, each as a load step,
//   its digit steps and a write-back step. The block takes a new word
//   only after it has published the result of the last one. A restart
//   word, or a sample that finds last, average and rate all zero, skips
//   the products and goes straight to publishing its result.
// Reset and stall:
//   Synchronous active-low reset returns the filter state and the
//   coefficient to their reset values and drops any pending result.
//   A stalled result word holds; the block may take one more input word
//   meanwhile and finishes it, then waits until the output register frees.
`include "ema_filter_with_extrema_variance_defines.svh"

module ema_filter_with_extrema_variance (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  emaev_pkg::in_word_t           in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output emaev_pkg::out_word_t          out_data,
  input  logic                          cfg_wr_en,
  input  logic [emaev_pkg::COEF_W-1:0]  cfg_wr_data
);

  // One-hot sequencer states.
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOAD = 5'b00010,
    S_MUL  = 5'b00100,
    S_POST = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  // Product being formed on the shared multiplier.
  typedef enum logic [2:0] {
    OP_NV,     // (avg - x) * c      -> new average
    OP_HIGH,   // (high - nv) * c    -> decayed peak
    OP_LOW,    // (low - nv) * c     -> decayed valley
    OP_SQR,    // |nv - x| squared   -> squared deviation
    OP_SQDEV   // (sq - dsq) * c     -> mean squared deviation
  } op_t;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;

  logic [emaev_pkg::COEF_W-1:0] coef_r, coef_nxt;

  // Filter state.
  logic signed [emaev_pkg::DATA_W-1:0] last_r, last_nxt;
  logic signed [emaev_pkg::DATA_W-1:0] avg_r, avg_nxt;
  logic signed [emaev_pkg::DATA_W-1:0] rate_r, rate_nxt;
  logic signed [emaev_pkg::DATA_W-1:0] high_r, high_nxt;
  logic signed [emaev_pkg::DATA_W-1:0] low_r, low_nxt;
  logic        [emaev_pkg::SQ_W-1:0]   sq_r, sq_nxt;

  // Per-word working registers.
  logic signed [emaev_pkg::DATA_W-1:0] x_r, x_nxt;
  logic        [emaev_pkg::DATA_W:0]   a_r, a_nxt;
  logic        [emaev_pkg::SQ_W-1:0]   dsq_r, dsq_nxt;

  // Digit-serial multiplier: multiplicand, multiplier shift register,
  // right-shifting accumulator and the shift register catching its low bits.
  logic signed [emaev_pkg::MUL_W-1:0]  m_r, m_nxt;
  logic        [emaev_pkg::MULT_W-1:0] mult_r, mult_nxt;
  logic signed [emaev_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic        [emaev_pkg::MULT_W-1:0] lo_r, lo_nxt;
  logic        [emaev_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;

  logic                  out_valid_r, out_valid_nxt;
  emaev_pkg::out_word_t  out_r, out_nxt;

  logic signed [emaev_pkg::ACC_W-1:0]  prod_w;
  logic signed [emaev_pkg::ACC_W-1:0]  sum_w;
  logic signed [emaev_pkg::DATA_W-1:0] nv_w;
  logic signed [emaev_pkg::DATA_W:0]   rdiff_w;
  logic signed [emaev_pkg::DATA_W+1:0] pd_w;
  logic signed [emaev_pkg::DATA_W+1:0] pabs_w;
  logic signed [emaev_pkg::DATA_W-1:0] blend_w;
  logic                                in_acc_w;
  logic                                out_free_w;
  logic                                first_w;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign in_acc_w   = in_valid && !in_stall;
  assign out_free_w = !out_valid_r || !out_stall;
  assign first_w    = (last_r == '0) && (avg_r == '0) && (rate_r == '0);

  // One digit step: add multiplicand times the low digit, then shift right.
  assign prod_w = m_r * $signed({1'b0, mult_r[emaev_pkg::DIGIT_W-1:0]});
  assign sum_w  = acc_r + prod_w;

  // Write-back arithmetic from the finished product.
  assign nv_w    = x_r + $signed(acc_r[emaev_pkg::DATA_W-1:0]);
  assign rdiff_w = {nv_w[emaev_pkg::DATA_W-1], nv_w} - {avg_r[emaev_pkg::DATA_W-1], avg_r};
  assign pd_w    = acc_r[emaev_pkg::DATA_W+1:0];
  assign pabs_w  = pd_w[emaev_pkg::DATA_W+1] ? -pd_w : pd_w;
  assign blend_w = avg_r + $signed(acc_r[emaev_pkg::DATA_W-1:0]);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    coef_nxt      = coef_r;
    last_nxt      = last_r;
    avg_nxt       = avg_r;
    rate_nxt      = rate_r;
    high_nxt      = high_r;
    low_nxt       = low_r;
    sq_nxt        = sq_r;
    x_nxt         = x_r;
    a_nxt         = a_r;
    dsq_nxt       = dsq_r;
    m_nxt         = m_r;
    mult_nxt      = mult_r;
    acc_nxt       = acc_r;
    lo_nxt        = lo_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;

    if (cfg_wr_en) begin
      coef_nxt = cfg_wr_data;
    end

    // Drop the pending result once the receiver takes it.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc_w) begin
          x_nxt  = in_data.sample;
          op_nxt = OP_NV;
          if (in_data.mode) begin
            // Restart: clear filter state, report it.
            last_nxt  = '0;
            avg_nxt   = '0;
            rate_nxt  = '0;
            high_nxt  = emaev_pkg::DATA_MIN;
            low_nxt   = emaev_pkg::DATA_MAX;
            sq_nxt    = '0;
            state_nxt = S_DONE;
          end else if (first_w) begin
            // Empty filter: load the sample as the average.
            avg_nxt   = in_data.sample;
            last_nxt  = in_data.sample;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_LOAD;
          end
        end
      end

      S_LOAD: begin
        acc_nxt   = '0;
        lo_nxt    = '0;
        cnt_nxt   = emaev_pkg::CNT_COEF;
        mult_nxt  = {{(emaev_pkg::MULT_W-emaev_pkg::COEF_W){1'b0}}, coef_r};
        state_nxt = S_MUL;
        unique case (op_r)
          OP_NV: begin
            m_nxt = $signed({{(emaev_pkg::MUL_W-emaev_pkg::DATA_W){avg_r[emaev_pkg::DATA_W-1]}},
                             avg_r})
                  - $signed({{(emaev_pkg::MUL_W-emaev_pkg::DATA_W){x_r[emaev_pkg::DATA_W-1]}},
                             x_r});
          end
          OP_HIGH: begin
            m_nxt = $signed({{(emaev_pkg::MUL_W-emaev_pkg::DATA_W){high_r[emaev_pkg::DATA_W-1]}},
                             high_r})
                  - $signed({{(emaev_pkg::MUL_W-emaev_pkg::DATA_W){avg_r[emaev_pkg::DATA_W-1]}},
                             avg_r});
          end
          OP_LOW: begin
            m_nxt = $signed({{(emaev_pkg::MUL_W-emaev_pkg::DATA_W){low_r[emaev_pkg::DATA_W-1]}},
                             low_r})
                  - $signed({{(emaev_pkg::MUL_W-emaev_pkg::DATA_W){avg_r[emaev_pkg::DATA_W-1]}},
                             avg_r});
          end
          OP_SQR: begin
            m_nxt    = $signed({{(emaev_pkg::MUL_W-emaev_pkg::DATA_W-1){1'b0}}, a_r});
            mult_nxt = a_r[emaev_pkg::MULT_W-1:0];
            cnt_nxt  = emaev_pkg::CNT_SQR;
          end
          OP_SQDEV: begin
            m_nxt = $signed({{(emaev_pkg::MUL_W-emaev_pkg::SQ_W){1'b0}}, sq_r})
                  - $signed({{(emaev_pkg::MUL_W-emaev_pkg::SQ_W){1'b0}}, dsq_r});
          end
          default: begin
            m_nxt = m_r;
          end
        endcase
      end

      S_MUL: begin
        acc_nxt  = sum_w >>> emaev_pkg::DIGIT_W;
        lo_nxt   = {sum_w[emaev_pkg::DIGIT_W-1:0], lo_r[emaev_pkg::MULT_W-1:emaev_pkg::DIGIT_W]};
        mult_nxt = mult_r >> emaev_pkg::DIGIT_W;
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_POST;
        end
      end

      S_POST: begin
        state_nxt = S_LOAD;
        unique case (op_r)
          OP_NV: begin
            avg_nxt = nv_w;
            if (rdiff_w[emaev_pkg::DATA_W] != rdiff_w[emaev_pkg::DATA_W-1]) begin
              rate_nxt = rdiff_w[emaev_pkg::DATA_W] ? emaev_pkg::DATA_MIN : emaev_pkg::DATA_MAX;
            end else begin
              rate_nxt = rdiff_w[emaev_pkg::DATA_W-1:0];
            end
            // The product itself is nv - x.
            a_nxt  = pabs_w[emaev_pkg::DATA_W:0];
            op_nxt = OP_HIGH;
          end
          OP_HIGH: begin
            high_nxt = (high_r < x_r) ? x_r : blend_w;
            op_nxt   = OP_LOW;
          end
          OP_LOW: begin
            low_nxt = (x_r < low_r) ? x_r : blend_w;
            op_nxt  = OP_SQR;
          end
          OP_SQR: begin
            // Deviation of 2^32 would overflow the square: saturate.
            if (a_r[emaev_pkg::DATA_W]) begin
              dsq_nxt = '1;
            end else begin
              dsq_nxt = {acc_r[emaev_pkg::DATA_W-1:0],
                         lo_r[emaev_pkg::MULT_W-1:emaev_pkg::MULT_W-emaev_pkg::COEF_W]};
            end
            op_nxt = OP_SQDEV;
          end
          OP_SQDEV: begin
            sq_nxt    = dsq_r + acc_r[emaev_pkg::SQ_W-1:0];
            last_nxt  = x_r;
            op_nxt    = OP_NV;
            state_nxt = S_DONE;
          end
          default: begin
            op_nxt = OP_NV;
          end
        endcase
      end

      S_DONE: begin
        // Hold until the output register is free, then publish the state.
        if (out_free_w) begin
          out_nxt.average         = avg_r;
          out_nxt.rate            = rate_r;
          out_nxt.peak_high       = high_r;
          out_nxt.peak_low        = low_r;
          out_nxt.mean_square_dev = sq_r;
          out_valid_nxt           = 1'b1;
          state_nxt               = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and filter state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_NV;
      coef_r      <= emaev_pkg::COEF_RESET;
      last_r      <= '0;
      avg_r       <= '0;
      rate_r      <= '0;
      high_r      <= emaev_pkg::DATA_MIN;
      low_r       <= emaev_pkg::DATA_MAX;
      sq_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      coef_r      <= coef_nxt;
      last_r      <= last_nxt;
      avg_r       <= avg_nxt;
      rate_r      <= rate_nxt;
      high_r      <= high_nxt;
      low_r       <= low_nxt;
      sq_r        <= sq_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers: no reset.
  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    a_r    <= a_nxt;
    dsq_r  <= dsq_nxt;
    m_r    <= m_nxt;
    mult_r <= mult_nxt;
    acc_r  <= acc_nxt;
    lo_r   <= lo_nxt;
    cnt_r  <= cnt_nxt;
    out_r  <= out_nxt;
  end

  // An accepted word keeps the input side stalled on the next cycle.
  `EMAEV_ASSERT_NEXT(a_busy_after_accept, in_acc_w, in_stall)
  // Finishing with a free output slot publishes a result and returns to idle.
  `EMAEV_ASSERT_NEXT(a_done_publishes, (state_r == S_DONE) && out_free_w,
                     out_valid_r && (state_r == S_IDLE))
  // A restart word leaves the trackers at their reset values.
  `EMAEV_ASSERT_NEXT(a_restart_clears, in_acc_w && in_data.mode,
                     (high_r == emaev_pkg::DATA_MIN) && (low_r == emaev_pkg::DATA_MAX) && (sq_r == '0))
  // Coefficient products run the multiplier only with a digit count in range.
  `EMAEV_ASSERT_NOW(a_mul_count, (state_r == S_MUL) && (op_r != OP_SQR), cnt_r <= emaev_pkg::CNT_COEF)

endmodule
